// File: rtl/icv_pkg.sv
package icv_pkg;

	// Character codes recognised by the parser.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	// Field limits and saturation points.
	localparam logic [8:0] OCTET_MAX     = 9'd255;
	localparam logic [8:0] PREFIX_MAX    = 9'd32;
	localparam logic [8:0] VALUE_SAT     = 9'd256;
	localparam logic [1:0] DIGITS_SAT    = 2'd3;
	localparam logic [2:0] OCTETS_NEEDED = 3'd4;
	localparam logic [2:0] OCTETS_SAT    = 3'd7;

	// Parser state carried from one character to the next.
	typedef struct packed {
		logic       in_prefix;
		logic [2:0] octets_seen;
		logic [8:0] field_value;
		logic [1:0] field_digits;
		logic       field_leading_zero;
		logic       error_seen;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		in_prefix:          1'b0,
		octets_seen:        3'd0,
		field_value:        9'd0,
		field_digits:       2'd0,
		field_leading_zero: 1'b0,
		error_seen:         1'b0
	};

	// True when the current field has digits, no leading zero and fits the limit.
	function automatic logic field_ok(parse_state_t st, logic [8:0] limit);
		logic ok;
		ok = 1'b1;
		if (st.field_digits == 2'd0)
			ok = 1'b0;
		if (st.field_leading_zero && (st.field_digits > 2'd1))
			ok = 1'b0;
		if (st.field_value > limit)
			ok = 1'b0;
		return ok;
	endfunction

	// Closes an octet: checks it, counts it and clears the field.
	function automatic parse_state_t close_octet(parse_state_t st);
		parse_state_t r;
		r = st;
		if (!field_ok(st, OCTET_MAX))
			r.error_seen = 1'b1;
		if (st.octets_seen < OCTETS_SAT)
			r.octets_seen = st.octets_seen + 3'd1;
		r.field_value        = 9'd0;
		r.field_digits       = 2'd0;
		r.field_leading_zero = 1'b0;
		return r;
	endfunction

endpackage

// File: rtl/icv_step.sv
// Next-state and verdict logic for one character of the address text.
module icv_step (
	input  icv_pkg::parse_state_t cur,
	input  logic [7:0]            char_in,
	input  logic                  is_last,
	output icv_pkg::parse_state_t nxt,
	output logic                  valid_res
);

	icv_pkg::parse_state_t upd;
	icv_pkg::parse_state_t fin;
	logic [3:0]  digit;
	logic [11:0] scaled;
	logic        is_digit;

	assign is_digit = (char_in >= icv_pkg::CHAR_ZERO) && (char_in <= icv_pkg::CHAR_NINE);
	assign digit    = 4'(char_in - icv_pkg::CHAR_ZERO);
	// value * 10 + digit, as two shifts and an add
	assign scaled   = ({3'b000, cur.field_value} << 3) + ({3'b000, cur.field_value} << 1)
	                + {8'h00, digit};

	always_comb begin
		upd = cur;
		if (is_digit) begin
			if ((cur.field_digits == 2'd0) && (digit == 4'd0))
				upd.field_leading_zero = 1'b1;
			upd.field_value = (scaled > {3'b000, icv_pkg::VALUE_SAT}) ?
			                  icv_pkg::VALUE_SAT : scaled[8:0];
			if (cur.field_digits < icv_pkg::DIGITS_SAT)
				upd.field_digits = cur.field_digits + 2'd1;
		end else if (char_in == icv_pkg::CHAR_DOT) begin
			if (cur.in_prefix) begin
				upd.error_seen         = 1'b1;
				upd.field_value        = 9'd0;
				upd.field_digits       = 2'd0;
				upd.field_leading_zero = 1'b0;
			end else begin
				upd = icv_pkg::close_octet(cur);
				if (cur.octets_seen >= (icv_pkg::OCTETS_NEEDED - 3'd1))
					upd.error_seen = 1'b1;
			end
		end else if (char_in == icv_pkg::CHAR_SLASH) begin
			if (cur.in_prefix) begin
				upd.error_seen         = 1'b1;
				upd.field_value        = 9'd0;
				upd.field_digits       = 2'd0;
				upd.field_leading_zero = 1'b0;
			end else begin
				upd = icv_pkg::close_octet(cur);
				if (upd.octets_seen != icv_pkg::OCTETS_NEEDED)
					upd.error_seen = 1'b1;
				upd.in_prefix = 1'b1;
			end
		end else begin
			upd.error_seen = 1'b1;
		end
	end

	// Final checks that apply only on the last character of a string.
	always_comb begin
		fin = upd;
		if (upd.in_prefix) begin
			if (!icv_pkg::field_ok(upd, icv_pkg::PREFIX_MAX))
				fin.error_seen = 1'b1;
		end else begin
			fin = icv_pkg::close_octet(upd);
			if (fin.octets_seen != icv_pkg::OCTETS_NEEDED)
				fin.error_seen = 1'b1;
		end
	end

	assign valid_res = !fin.error_seen;
	assign nxt       = is_last ? icv_pkg::PARSE_RESET : upd;

endmodule

// File: rtl/ipv4_cidr_text_validator_unit.sv
// A verdict passes through the character stage and then the verdict register before it is presented.
// Throughput: one character per cycle, but for the stall on a held verdict.
// A held verdict stalls the input only once the next string's final character is in stage one.
// Reset: arst_n is asynchronous and active low; it empties both pipeline registers
// and returns the parser to its start state, with no strings in flight.
module ipv4_cidr_text_validator_unit (
	input  logic       clk,
	input  logic       arst_n,
	// Character stream.
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,   // is_last: marks the final character of the string
	// Verdict stream, one beat per string.
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);

	// The first stage holds the character being parsed. The parser state lives in
	// state_q and is updated in the same cycle that the character leaves stage one.
	logic [7:0] char_s1;
	logic       last_s1;
	logic       valid_s1;

	icv_pkg::parse_state_t state_q;
	icv_pkg::parse_state_t state_nxt;
	logic                  verdict;

	// The second stage holds the verdict until the downstream side takes it.
	logic res_s2;
	logic valid_s2;

	logic advance;

	// A character that ends a string can only move on when the verdict register is
	// free or is being emptied this cycle; any other character always moves on.
	assign advance  = valid_s1 && (!last_s1 || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	icv_step u_step (
		.cur       (state_q),
		.char_in   (char_s1),
		.is_last   (last_s1),
		.nxt       (state_nxt),
		.valid_res (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= icv_pkg::PARSE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_s2 <= verdict;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2};

endmodule
